// ===== rtl/core/hjbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hjbd_pkg
// Shared types and constants for the headset jack and hook button detector.
// ----------------------------------------------------------------------------
package hjbd_pkg;

	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CFG_W-1:0] DETECT_DELAY_RST  = CFG_W'(100);
	localparam logic [CFG_W-1:0] PLUG_SETTLE_RST   = CFG_W'(1000);
	localparam logic [CFG_W-1:0] UNPLUG_SETTLE_RST = CFG_W'(110);
	localparam logic [CFG_W-1:0] BTN_DEBOUNCE_RST  = CFG_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DETECT_DELAY  = 2'd0,
		REG_PLUG_SETTLE   = 2'd1,
		REG_UNPLUG_SETTLE = 2'd2,
		REG_BTN_DEBOUNCE  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DEV_NONE  = 2'd0,
		DEV_MIC   = 2'd1,
		DEV_PHONE = 2'd2
	} dev_kind_t;

	typedef enum logic [1:0] {
		KEY_NONE    = 2'd0,
		KEY_PRESS   = 2'd1,
		KEY_RELEASE = 2'd2
	} key_evt_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_DELAY  = 3'b010,
		PH_SETTLE = 3'b100
	} det_phase_t;

endpackage : hjbd_pkg
`default_nettype wire

// ===== rtl/core/headset_jack_and_button_detector_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// headset_jack_and_button_detector_core
// A transferred tick is held in the input register and moves on into the
// result register once that register is empty or being taken. Throughput:
// one tick per cycle while out_stall is low; the detector state updates in
// one pass of small compare/decrement logic.
// Reset: arst_n clears the valid flags and detector state, loads register defaults and drops out_valid.
// ----------------------------------------------------------------------------
// Tracks jack insertion and removal with a detect delay and a settle time,
// classifies the device, controls mic bias, and debounces the hook line into
// media key press and release events while a headset with mic is present.
// ----------------------------------------------------------------------------
module headset_jack_and_button_detector_core
	import hjbd_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// tick input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 jack_level,
	input  wire logic                 hook_level,
	input  wire logic                 debug_board_level,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                device_kind,
	output logic                      mic_bias_on,
	output logic [1:0]                key_event,
	output logic                      detecting,
	// configuration write port
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int SAT_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	// Clamp a register value into the counter range.
	function automatic logic [COUNT_BITS-1:0] sat_count(input logic [CFG_W-1:0] v);
		logic [SAT_W-1:0] v_ext;
		v_ext = SAT_W'(v);
		if (v_ext > SAT_W'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return COUNT_BITS'(v_ext);
	endfunction

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0] detect_delay_q;
	logic [CFG_W-1:0] plug_settle_q;
	logic [CFG_W-1:0] unplug_settle_q;
	logic [CFG_W-1:0] btn_debounce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_delay_q  <= DETECT_DELAY_RST;
			plug_settle_q   <= PLUG_SETTLE_RST;
			unplug_settle_q <= UNPLUG_SETTLE_RST;
			btn_debounce_q  <= BTN_DEBOUNCE_RST;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DETECT_DELAY:  detect_delay_q  <= cfg_data;
				REG_PLUG_SETTLE:   plug_settle_q   <= cfg_data;
				REG_UNPLUG_SETTLE: unplug_settle_q <= cfg_data;
				REG_BTN_DEBOUNCE:  btn_debounce_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ----------------------------------------------------------- handshake
	// Stage 1 holds the sampled tick; it advances into the result register
	// whenever that register is empty or being taken this cycle.
	logic valid_s1;
	logic jack_s1;
	logic hook_s1;
	logic dbg_s1;
	logic out_valid_q;
	logic advance_s1;

	assign advance_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			jack_s1 <= jack_level;
			hook_s1 <= hook_level;
			dbg_s1  <= debug_board_level;
		end
	end

	// -------------------------------------------------------- detector state
	dev_kind_t             dev_q,    dev_n;
	det_phase_t            phase_q,  phase_n;
	logic [COUNT_BITS-1:0] dcnt_q,   dcnt_n;
	logic                  bias_q,   bias_n;
	logic                  pjack_q,  pjack_n;
	logic                  seen_q,   seen_n;
	logic                  phook_q,  phook_n;
	logic [COUNT_BITS-1:0] bcnt_q,   bcnt_n;
	logic                  barmed_q, barmed_n;
	logic                  bdown_q,  bdown_n;
	logic                  bign_q,   bign_n;
	key_evt_t              key_n;
	logic                  just_armed;

	always_comb begin
		dev_n      = dev_q;
		phase_n    = phase_q;
		dcnt_n     = dcnt_q;
		bias_n     = bias_q;
		pjack_n    = pjack_q;
		seen_n     = seen_q;
		bcnt_n     = bcnt_q;
		barmed_n   = barmed_q;
		bdown_n    = bdown_q;
		bign_n     = bign_q;
		key_n      = KEY_NONE;
		just_armed = 1'b0;

		// Jack watch: not looked at while settling. The first tick counts
		// as a change from the unplugged level.
		if (phase_q != PH_SETTLE && (!seen_q || jack_s1 != pjack_q)) begin
			seen_n  = 1'b1;
			pjack_n = jack_s1;
			if ((dev_q == DEV_NONE) != jack_s1) begin
				bign_n = 1'b1;
				if (phase_q == PH_IDLE) begin
					phase_n    = PH_DELAY;
					dcnt_n     = sat_count(detect_delay_q);
					just_armed = 1'b1;
				end
			end
		end

		// Detect delay, then settle, then classify.
		if (!just_armed && phase_q != PH_IDLE) begin
			if (dcnt_q <= COUNT_ONE) begin
				if (phase_q == PH_DELAY) begin
					bias_n  = 1'b1;
					phase_n = PH_SETTLE;
					dcnt_n  = sat_count((dev_q != DEV_NONE) ? unplug_settle_q
					                                        : plug_settle_q);
				end else begin
					if (jack_s1) begin
						if (dev_q == DEV_MIC) begin
							bdown_n = 1'b0;
						end
						dev_n  = DEV_NONE;
						bias_n = 1'b0;
					end else begin
						// Debug board attached leaves the kind at none.
						if (dev_q == DEV_NONE && dbg_s1) begin
							if (hook_s1) begin
								dev_n = DEV_PHONE;
							end else begin
								dev_n   = DEV_MIC;
								bdown_n = 1'b0;
								bign_n  = 1'b0;
							end
						end
						if (hook_s1) begin
							bias_n = 1'b0;
						end
					end
					phase_n = PH_IDLE;
					dcnt_n  = '0;
				end
			end else begin
				dcnt_n = dcnt_q - COUNT_ONE;
			end
		end

		// Button watch: hook edges restart debounce in headset-with-mic state
		// with no detection running; a running timer completes regardless.
		if (hook_s1 != phook_q && dev_n == DEV_MIC && phase_n == PH_IDLE) begin
			barmed_n = 1'b1;
			bcnt_n   = sat_count(btn_debounce_q);
		end else if (barmed_q) begin
			if (bcnt_q <= COUNT_ONE) begin
				barmed_n = 1'b0;
				bcnt_n   = '0;
				if (!bign_n) begin
					if (hook_s1) begin
						key_n   = KEY_PRESS;
						bdown_n = 1'b1;
					end else if (bdown_n) begin
						key_n   = KEY_RELEASE;
						bdown_n = 1'b0;
					end
				end
			end else begin
				bcnt_n = bcnt_q - COUNT_ONE;
			end
		end
		phook_n = hook_s1;
	end

	// Commit the state only when the tick moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q    <= DEV_NONE;
			phase_q  <= PH_IDLE;
			dcnt_q   <= '0;
			bias_q   <= 1'b0;
			pjack_q  <= 1'b1;
			seen_q   <= 1'b0;
			phook_q  <= 1'b0;
			bcnt_q   <= '0;
			barmed_q <= 1'b0;
			bdown_q  <= 1'b0;
			bign_q   <= 1'b0;
		end else if (advance_s1) begin
			dev_q    <= dev_n;
			phase_q  <= phase_n;
			dcnt_q   <= dcnt_n;
			bias_q   <= bias_n;
			pjack_q  <= pjack_n;
			seen_q   <= seen_n;
			phook_q  <= phook_n;
			bcnt_q   <= bcnt_n;
			barmed_q <= barmed_n;
			bdown_q  <= bdown_n;
			bign_q   <= bign_n;
		end
	end

	// ------------------------------------------------------- result register
	logic [1:0] kind_q;
	logic       bias_out_q;
	logic [1:0] key_q;
	logic       det_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			kind_q     <= dev_n;
			bias_out_q <= bias_n;
			key_q      <= key_n;
			det_q      <= (phase_n != PH_IDLE);
		end
	end

	assign out_valid   = out_valid_q;
	assign device_kind = kind_q;
	assign mic_bias_on = bias_out_q;
	assign key_event   = key_q;
	assign detecting   = det_q;

endmodule : headset_jack_and_button_detector_core
`default_nettype wire

// ===== tb/hjbd_result_compare.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hjbd_result_compare
// Watches the tick and result channels of the headset jack and button
// detector, keeps its own model of the detector state and timer registers,
// and compares every transferred result field by field, in order.
// ----------------------------------------------------------------------------
module hjbd_result_compare
	import hjbd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic                 jack_level,
	input  wire logic                 hook_level,
	input  wire logic                 debug_board_level,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [1:0]           device_kind,
	input  wire logic                 mic_bias_on,
	input  wire logic [1:0]           key_event,
	input  wire logic                 detecting,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        compared,
	output int                        key_reports
);

	typedef struct packed {
		dev_kind_t kind;
		logic      bias;
		key_evt_t  key;
		logic      busy;
	} tick_result_t;

	localparam int MAX_REPORTS = 40;

	// timer registers
	logic [CFG_W-1:0] delay_ticks;
	logic [CFG_W-1:0] plug_ticks;
	logic [CFG_W-1:0] unplug_ticks;
	logic [CFG_W-1:0] debounce_ticks;

	// detector state
	dev_kind_t        dev;
	det_phase_t       phase;
	logic [CFG_W-1:0] det_left;
	logic             bias;
	logic             last_jack;
	logic             seen;
	logic             last_hook;
	logic [CFG_W-1:0] btn_left;
	logic             armed;
	logic             key_down;
	logic             ignore_keys;

	tick_result_t     pending_results[$];

	function automatic tick_result_t detect_tick(input logic jack, input logic hook,
			input logic dbg);
		tick_result_t r;
		logic         just_armed;
		key_evt_t     key;
		just_armed = 1'b0;
		key = KEY_NONE;

		// jack watch; the jack is not looked at while settling
		if (phase != PH_SETTLE && (!seen || jack != last_jack)) begin
			seen = 1'b1;
			last_jack = jack;
			if ((dev == DEV_NONE) != (jack == 1'b1)) begin
				ignore_keys = 1'b1;
				if (phase == PH_IDLE) begin
					phase = PH_DELAY;
					det_left = delay_ticks;
					just_armed = 1'b1;
				end
			end
		end

		// detect delay, then settle, then classify
		if (!just_armed && phase != PH_IDLE) begin
			if (det_left <= 1) begin
				if (phase == PH_DELAY) begin
					bias = 1'b1;
					phase = PH_SETTLE;
					det_left = (dev != DEV_NONE) ? unplug_ticks : plug_ticks;
				end else begin
					if (jack) begin
						if (dev == DEV_MIC)
							key_down = 1'b0;
						dev = DEV_NONE;
						bias = 1'b0;
					end else begin
						// a debug board leaves the device at none
						if (dev == DEV_NONE && dbg) begin
							if (hook) begin
								dev = DEV_PHONE;
							end else begin
								dev = DEV_MIC;
								key_down = 1'b0;
								ignore_keys = 1'b0;
							end
						end
						if (hook)
							bias = 1'b0;
					end
					phase = PH_IDLE;
					det_left = '0;
				end
			end else begin
				det_left = det_left - 1'b1;
			end
		end

		// hook debounce
		if (hook != last_hook && dev == DEV_MIC && phase == PH_IDLE) begin
			armed = 1'b1;
			btn_left = debounce_ticks;
		end else if (armed) begin
			if (btn_left <= 1) begin
				armed = 1'b0;
				btn_left = '0;
				if (!ignore_keys) begin
					if (hook) begin
						key = KEY_PRESS;
						key_down = 1'b1;
					end else if (key_down) begin
						key = KEY_RELEASE;
						key_down = 1'b0;
					end
				end
			end else begin
				btn_left = btn_left - 1'b1;
			end
		end
		last_hook = hook;

		r.kind = dev;
		r.bias = bias;
		r.key = key;
		r.busy = (phase != PH_IDLE);
		return r;
	endfunction

	function automatic void flag_field(input string field, input int want, input int got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
		else if (fail_count == MAX_REPORTS + 1)
			$display("further mismatches are counted but not shown");
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		tick_result_t got;
		if (!arst_n) begin
			delay_ticks <= DETECT_DELAY_RST;
			plug_ticks <= PLUG_SETTLE_RST;
			unplug_ticks <= UNPLUG_SETTLE_RST;
			debounce_ticks <= BTN_DEBOUNCE_RST;
			dev = DEV_NONE;
			phase = PH_IDLE;
			det_left = '0;
			bias = 1'b0;
			last_jack = 1'b1;
			seen = 1'b0;
			last_hook = 1'b0;
			btn_left = '0;
			armed = 1'b0;
			key_down = 1'b0;
			ignore_keys = 1'b0;
			pending_results.delete();
			fail_count = 0;
			pending = 0;
			compared = 0;
			key_reports = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.kind = dev_kind_t'(device_kind);
				got.bias = mic_bias_on;
				got.key = key_evt_t'(key_event);
				got.busy = detecting;
				if (pending_results.size() == 0) begin
					fail_count++;
					$error("result transferred with no tick outstanding");
				end else begin
					want = pending_results.pop_front();
					compared++;
					if (got.key != KEY_NONE)
						key_reports++;
					if (got.kind !== want.kind)
						flag_field("device_kind", want.kind, got.kind);
					if (got.bias !== want.bias)
						flag_field("mic_bias_on", want.bias, got.bias);
					if (got.key !== want.key)
						flag_field("key_event", want.key, got.key);
					if (got.busy !== want.busy)
						flag_field("detecting", want.busy, got.busy);
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(detect_tick(jack_level, hook_level,
					debug_board_level));
			pending = pending_results.size();
			if (cfg_write_en) begin
				case (cfg_index)
					REG_DETECT_DELAY:  delay_ticks <= cfg_data;
					REG_PLUG_SETTLE:   plug_ticks <= cfg_data;
					REG_UNPLUG_SETTLE: unplug_ticks <= cfg_data;
					REG_BTN_DEBOUNCE:  debounce_ticks <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule : hjbd_result_compare

// ===== tb/headset_jack_and_button_detector_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// headset_jack_and_button_detector_core_tb
// Drives millisecond ticks into the jack and hook button detector: a short
// directed run over plug, unplug, headphone, debug board and key press and
// release, then random plug/button sessions mixed with noise under three
// timer settings and three idling mixes, and a last run at the largest timer
// values. A separate compare module predicts and checks every result.
// ----------------------------------------------------------------------------
module headset_jack_and_button_detector_core_tb;
	import hjbd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_EVERY  = 500;  // receiver cycles between long hold-offs
	localparam int HOLD_LEN    = 40;   // cycles in one long hold-off

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 jack_level;
	logic                 hook_level;
	logic                 debug_board_level;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           device_kind;
	logic                 mic_bias_on;
	logic [1:0]           key_event;
	logic                 detecting;
	logic                 cfg_write_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int fail_count;
	int pending;
	int compared;
	int key_reports;

	// stimulus bookkeeping
	int sent;
	int settings;
	int send_pct;
	int recv_pct;
	int cycles;

	// our copy of the timer values, used only to size the sessions
	int delay_t;
	int plug_t;
	int unplug_t;
	int debounce_t;

	headset_jack_and_button_detector_core dut (.*);

	hjbd_result_compare result_compare (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a transfer never completes.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: stall at random per the current mix, and every so often hold
	// off for a long stretch so the block fills up and stalls its tick input.
	initial begin
		int rcv_cycle;
		int hold_left;
		rcv_cycle = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			rcv_cycle++;
			if (rcv_cycle % HOLD_EVERY == HOLD_EVERY / 2)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_pct);
			end
		end
	end

	// Offer one tick, with random idle cycles ahead of it, and hold it until
	// it is transferred. Returns at the edge of the transfer with valid still
	// high; the caller either offers the next tick or drops valid.
	task automatic send_tick(input logic j, input logic h, input logic d);
		bit taken;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		jack_level <= j;
		hook_level <= h;
		debug_board_level <= d;
		// look at stall on the falling edge ahead of the rising edge, when it is settled
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	task automatic hold_levels(input logic j, input logic h, input logic d, input int n);
		repeat (n) send_tick(j, h, d);
	endtask

	// Drop valid and wait until every transferred tick has its result back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_timer(input cfg_reg_t idx, input int val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
	endtask

	// Reprogram all four timers once the block has gone quiet.
	task automatic set_timers(input int d, input int p, input int u, input int b);
		drain();
		// give the two-stage pipeline time to empty
		repeat (4) @(posedge clk);
		write_timer(REG_DETECT_DELAY, d);
		write_timer(REG_PLUG_SETTLE, p);
		write_timer(REG_UNPLUG_SETTLE, u);
		write_timer(REG_BTN_DEBOUNCE, b);
		cfg_write_en <= 1'b0;
		delay_t = d;
		plug_t = p;
		unplug_t = u;
		debounce_t = b;
		settings++;
	endtask

	// Hook hold time: mostly long enough to pass the debounce, sometimes a
	// glitch that a later edge restarts.
	function automatic int press_len();
		if ($urandom_range(3) == 0)
			return $urandom_range(1, debounce_t + 1);
		return debounce_t + $urandom_range(1, 3);
	endfunction

	// Random sessions: mostly clean plug, button and unplug sequences long
	// enough to get through detection, the rest noise and broken sequences.
	task automatic play_sessions(input int upto);
		int kind;
		int run;
		int settle;
		while (sent < upto) begin
			settle = (plug_t > unplug_t) ? plug_t : unplug_t;
			run = delay_t + settle + 3;
			kind = $urandom_range(0, 11);
			case (kind)
				0, 1, 2, 3: begin
					// headset with mic, then a few key presses
					hold_levels(1'b0, 1'b0, 1'b1, run + $urandom_range(0, 2));
					repeat ($urandom_range(1, 4)) begin
						hold_levels(1'b0, 1'b1, 1'b1, press_len());
						hold_levels(1'b0, 1'b0, 1'b1, press_len());
					end
				end
				4: hold_levels(1'b0, 1'b1, 1'b1, run);
				5: hold_levels(1'b0, 1'($urandom_range(1)), 1'b0, run);
				6, 7: hold_levels(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), run);
				8: begin
					repeat ($urandom_range(1, 6))
						send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
							1'($urandom_range(1)));
				end
				9: begin
					// jack bounce, landing in the delay or the settle time
					repeat ($urandom_range(2, 5))
						hold_levels(1'($urandom_range(1)), 1'b0, 1'b1,
							$urandom_range(1, delay_t + settle + 1));
				end
				10: begin
					// pull the plug while a key decision is pending
					hold_levels(1'b0, 1'b1, 1'b1, $urandom_range(1, debounce_t + 1));
					hold_levels(1'b1, 1'b1, 1'b1, run);
				end
				default: drain();
			endcase
		end
	endtask

	initial begin
		sent = 0;
		settings = 0;
		send_pct = 30;
		recv_pct = 70;
		delay_t = DETECT_DELAY_RST;
		plug_t = PLUG_SETTLE_RST;
		unplug_t = UNPLUG_SETTLE_RST;
		debounce_t = BTN_DEBOUNCE_RST;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		jack_level <= 1'b1;
		hook_level <= 1'b0;
		debug_board_level <= 1'b1;
		cfg_write_en <= 1'b0;
		cfg_index <= REG_DETECT_DELAY;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset timers: the first tick counts as a plug, and the
		// jack moves again while the detect delay runs.
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b1, 1'b0, 1'b1);
		send_tick(1'b0, 1'b1, 1'b1);

		// Directed, all timers zero: every timer runs out on the next tick.
		set_timers(0, 0, 0, 0);
		hold_levels(1'b0, 1'b0, 1'b1, 4);  // headset with mic
		hold_levels(1'b0, 1'b1, 1'b1, 2);  // key press
		hold_levels(1'b0, 1'b0, 1'b1, 2);  // key release
		hold_levels(1'b1, 1'b0, 1'b1, 4);  // unplug
		hold_levels(1'b0, 1'b1, 1'b1, 3);  // headphone
		hold_levels(1'b1, 1'b1, 1'b1, 3);  // unplug
		hold_levels(1'b0, 1'b0, 1'b0, 3);  // debug board

		// Random sessions: sender idles less, receiver more.
		set_timers($urandom_range(0, 5), $urandom_range(1, 12), $urandom_range(0, 6),
			$urandom_range(0, 5));
		play_sessions(330);

		// Swap the idling mix.
		send_pct = 70;
		recv_pct = 30;
		set_timers($urandom_range(1, 6), $urandom_range(0, 10), $urandom_range(1, 8),
			$urandom_range(1, 6));
		play_sessions(630);

		// No idling at all, apart from the receiver's long hold-offs.
		send_pct = 0;
		recv_pct = 0;
		set_timers($urandom_range(0, 4), $urandom_range(0, 8), $urandom_range(0, 5),
			$urandom_range(0, 4));
		play_sessions(930);

		// Largest timers last, since a timer loaded here never runs out.
		send_pct = 30;
		recv_pct = 30;
		set_timers(65535, 65535, 65535, 65535);
		hold_levels(1'b0, 1'b1, 1'b1, 5);
		hold_levels(1'b0, 1'b0, 1'b1, 5);
		hold_levels(1'b1, 1'b0, 1'b1, 5);
		hold_levels(1'b0, 1'b0, 1'b0, 5);

		// Wait out the last results, then a few more cycles for strays.
		drain();
		repeat (6) @(posedge clk);
		@(negedge clk);
		$display("Run covered %0d ticks over %0d timer settings (zero, largest, random),",
			sent, settings + 1);
		$display("with %0d results compared and %0d key events reported.",
			compared, key_reports);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule : headset_jack_and_button_detector_core_tb

// ===== sim.f =====
rtl/core/hjbd_pkg.sv
rtl/core/headset_jack_and_button_detector_core.sv
tb/hjbd_result_compare.sv
tb/headset_jack_and_button_detector_core_tb.sv
